/* rtl/core/mbps_pkg.sv */
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants for the masked byte pattern scanner
// Holds the chain size, field widths, op and register codes, and the beat
// payload types of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

  // chain capacity and offset counter width
  localparam int MAX_PATTERN = 64;
  localparam int OFFSET_BITS = 32;
  localparam int SEL_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LENC_W      = $clog2(MAX_PATTERN + 1);

  // fixed field widths
  localparam int LEN_W    = 7;
  localparam int COUNT_W  = 16;
  localparam int ADDR_W   = 48;
  localparam int ENTRY_W  = 6;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 48;

  // item op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HITS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 2'd2;

  typedef struct packed {
    logic              op;
    logic [ENTRY_W-1:0] entry_index;
    logic [BYTE_W-1:0] entry_value;
    logic [BYTE_W-1:0] entry_mask;
    logic [BYTE_W-1:0] data_byte;
    logic              last_in_region;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic [ADDR_W-1:0]  hit_address;
    logic [COUNT_W-1:0] hit_count;
    logic               limit_reached;
    logic               region_end;
  } result_t;

  // control from the top level to the chain
  typedef struct packed {
    logic load;   // load beat accepted
    logic shift;  // data beat accepted
    logic flush;  // region ended with the beat in flight: shift from an empty chain
    logic clear;  // region ended and no data beat follows: empty the chain
  } chain_ctl_t;

  // control from the chain to one cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // one data beat between the chain and the report stage
  typedef struct packed {
    logic                   valid;
    logic                   last;
    logic [OFFSET_BITS-1:0] start;
  } stage_t;

endpackage

`default_nettype wire

/* rtl/core/mbps_item_if.sv */
// ----------------------------------------------------------------------------
// mbps_item_if: input channel of the scanner
// Carries valid, ready and one load or data item per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbps_item_if;
  logic            valid;
  logic            ready;
  mbps_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/mbps_result_if.sv */
// ----------------------------------------------------------------------------
// mbps_result_if: result channel of the scanner
// Carries valid, ready and one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbps_result_if;
  logic              valid;
  logic              ready;
  mbps_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/mbps_cell.sv */
// ----------------------------------------------------------------------------
// mbps_cell: one pattern position of the match chain
// Stores a value and mask byte and the partial match bit; on each data beat
// takes the neighbor's bit and ANDs it with its own masked compare.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mbps_pkg::cell_ctl_t         ctl,
  input  wire logic                        load_en,
  input  wire logic [mbps_pkg::BYTE_W-1:0] entry_value,
  input  wire logic [mbps_pkg::BYTE_W-1:0] entry_mask,
  input  wire logic [mbps_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                        prev_match,
  output logic                             match
);

  logic [mbps_pkg::BYTE_W-1:0] value;
  logic [mbps_pkg::BYTE_W-1:0] mask;
  logic                        eq;

  // masked compare against the broadcast byte
  assign eq = (data_byte & mask) == (value & mask);

  // hold entry, advance partial match
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      mask  <= '0;
      match <= 1'b0;
    end else begin
      if (load_en) begin
        value <= entry_value;
        mask  <= entry_mask;
      end
      if (ctl.shift) begin
        match <= prev_match & eq;
      end else if (ctl.clear) begin
        match <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mbps_chain.sv */
// ----------------------------------------------------------------------------
// mbps_chain: row of match cells
// Each cell hands its partial match bit to the next on every data beat but
// the first after a region end; the first cell always sees a match before it.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_chain (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire mbps_pkg::chain_ctl_t                ctl,
  input  wire logic [mbps_pkg::ENTRY_W-1:0]        entry_index,
  input  wire logic [mbps_pkg::BYTE_W-1:0]         entry_value,
  input  wire logic [mbps_pkg::BYTE_W-1:0]         entry_mask,
  input  wire logic [mbps_pkg::BYTE_W-1:0]         data_byte,
  output logic      [mbps_pkg::MAX_PATTERN-1:0]    match_vec
);

  mbps_pkg::cell_ctl_t cell_ctl;

  assign cell_ctl.shift = ctl.shift;
  assign cell_ctl.clear = ctl.clear;

  for (genvar j = 0; j < mbps_pkg::MAX_PATTERN; j++) begin : g_cell
    logic prev;
    logic load_en;

    // drop the neighbor's bit when the previous region just ended
    if (j == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = match_vec[j-1] & ~ctl.flush;
    end

    assign load_en = ctl.load && (32'(entry_index) == j);

    mbps_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (cell_ctl),
      .load_en     (load_en),
      .entry_value (entry_value),
      .entry_mask  (entry_mask),
      .data_byte   (data_byte),
      .prev_match  (prev),
      .match       (match_vec[j])
    );
  end

endmodule

`default_nettype wire

/* rtl/core/mbps_report.sv */
// ----------------------------------------------------------------------------
// mbps_report: hit decision and result register
// Picks the chain bit at the pattern end, applies the hit limit, keeps the
// per-region hit count and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_report (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire mbps_pkg::stage_t                    s1,
  input  wire logic [mbps_pkg::MAX_PATTERN-1:0]    match_vec,
  input  wire logic [mbps_pkg::LENC_W-1:0]         len_c,
  input  wire logic [mbps_pkg::COUNT_W-1:0]        max_hits,
  input  wire logic [mbps_pkg::ADDR_W-1:0]         base_address,
  output logic                                     take,
  mbps_result_if.source                            result
);

  logic [mbps_pkg::COUNT_W-1:0] hits_seen;
  logic [mbps_pkg::SEL_W-1:0]   sel;
  logic                         hit;
  logic [mbps_pkg::COUNT_W-1:0] hits_next;

  // result register is free or drains this cycle
  assign take = !result.valid || result.ready;

  assign sel = mbps_pkg::SEL_W'(len_c - mbps_pkg::LENC_W'(1));
  assign hit = (len_c != '0) && match_vec[sel] && (hits_seen < max_hits);
  assign hits_next = hits_seen + mbps_pkg::COUNT_W'(hit);

  // hold result until taken, advance hit count per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      hits_seen    <= '0;
    end else if (take) begin
      result.valid <= s1.valid;
      if (s1.valid) begin
        hits_seen <= s1.last ? '0 : hits_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && s1.valid) begin
      result.data.hit           <= hit;
      result.data.hit_address   <= hit ?
          (base_address + mbps_pkg::ADDR_W'(s1.start)) : '0;
      result.data.hit_count     <= hits_next;
      result.data.limit_reached <= (hits_next >= max_hits);
      result.data.region_end    <= s1.last;
    end
  end

  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.hit |-> result.data.hit_count != '0)
    else $error("hit reported with zero hit count");

  a_miss_no_addr: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.data.hit |-> result.data.hit_address == '0)
    else $error("address on a result without hit");

  a_region_reset: assert property (@(posedge clk) disable iff (rst)
    take && s1.valid && s1.last |=> hits_seen == '0)
    else $error("hit count not cleared at region end");

endmodule

`default_nettype wire

/* rtl/core/masked_byte_pattern_scanner.sv */
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner: masked byte pattern search over a byte stream
// The accepting edge updates the chain cells and stage one; from stage one the
// hit decision is loaded into the result register, which holds it until taken.
// Throughput: one item per cycle; input stalls only while stage one is full and
// the result beat waits. Load beats give no result.
// Reset (synchronous, rst high): pattern, chain, offset and hit count clear,
// pattern_length 0, max_hits 65535, base_address 0; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_scanner (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  mbps_item_if.sink                                item,
  mbps_result_if.source                            result
);

  logic [mbps_pkg::LEN_W-1:0]       pattern_length;
  logic [mbps_pkg::COUNT_W-1:0]     max_hits;
  logic [mbps_pkg::ADDR_W-1:0]      base_address;
  logic [mbps_pkg::LENC_W-1:0]      len_c;
  logic [mbps_pkg::OFFSET_BITS-1:0] byte_offset;
  logic [mbps_pkg::OFFSET_BITS-1:0] back;
  logic [mbps_pkg::OFFSET_BITS-1:0] start_next;
  logic [mbps_pkg::MAX_PATTERN-1:0] match_vec;
  mbps_pkg::stage_t                 s1;
  mbps_pkg::chain_ctl_t             ctl;
  logic                             take;
  logic                             accept;
  logic                             data_take;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      max_hits       <= '1;
      base_address   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mbps_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_wdata[mbps_pkg::LEN_W-1:0];
        mbps_pkg::REG_MAX_HITS:       max_hits       <= cfg_wdata[mbps_pkg::COUNT_W-1:0];
        mbps_pkg::REG_BASE_ADDRESS:   base_address   <= cfg_wdata[mbps_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp length to chain capacity
  always_comb begin
    if (int'(pattern_length) > mbps_pkg::MAX_PATTERN) begin
      len_c = mbps_pkg::LENC_W'(mbps_pkg::MAX_PATTERN);
    end else begin
      len_c = mbps_pkg::LENC_W'(pattern_length);
    end
  end

  // input handshake: stage one moves when it is empty or the result register can take
  assign item.ready = !s1.valid || take;
  assign accept     = item.valid && item.ready;
  assign data_take  = accept && (item.data.op == mbps_pkg::OP_DATA);

  assign ctl.load  = accept && (item.data.op == mbps_pkg::OP_LOAD);
  assign ctl.shift = data_take;
  assign ctl.flush = s1.valid && s1.last;
  assign ctl.clear = s1.valid && s1.last && take && !data_take;

  // window start offset, floored at zero
  assign back       = mbps_pkg::OFFSET_BITS'(len_c) - mbps_pkg::OFFSET_BITS'(1);
  assign start_next = (byte_offset >= back) ? (byte_offset - back) : '0;

  // saturating byte offset, cleared after the region's last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
    end else if (data_take) begin
      if (item.data.last_in_region) begin
        byte_offset <= '0;
      end else if (byte_offset != '1) begin
        byte_offset <= byte_offset + mbps_pkg::OFFSET_BITS'(1);
      end
    end
  end

  // stage one: data beat whose chain update is in the cells
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (item.ready) begin
      s1.valid <= data_take;
    end
  end

  always_ff @(posedge clk) begin
    if (data_take) begin
      s1.last  <= item.data.last_in_region;
      s1.start <= start_next;
    end
  end

  mbps_chain u_chain (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .entry_index (item.data.entry_index),
    .entry_value (item.data.entry_value),
    .entry_mask  (item.data.entry_mask),
    .data_byte   (item.data.data_byte),
    .match_vec   (match_vec)
  );

  mbps_report u_report (
    .clk          (clk),
    .rst          (rst),
    .s1           (s1),
    .match_vec    (match_vec),
    .len_c        (len_c),
    .max_hits     (max_hits),
    .base_address (base_address),
    .take         (take),
    .result       (result)
  );

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1.valid && !take |=> s1.valid && $stable(s1.start) && $stable(s1.last))
    else $error("stage one beat lost under stall");

endmodule

`default_nettype wire
